// ===== sv/gms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Genotype marker statistics package
// Shared sizes, command codes, the per-marker tally word and divider structs.
// ----------------------------------------------------------------------------
package gms_pkg;

	localparam int MARKERS    = 1024;
	localparam int IDX_BITS   = $clog2(MARKERS);
	localparam int COUNT_BITS = 20;
	localparam int SUM_BITS   = COUNT_BITS + 1;
	localparam int REM_BITS   = SUM_BITS + 1;
	localparam int FRAC_BITS  = 16;
	localparam int Q_BITS     = FRAC_BITS + 1;
	localparam int CODE_BITS  = FRAC_BITS + 3;
	localparam int PROD_BITS  = 2 * Q_BITS;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [COUNT_BITS-1:0] called;
		logic [SUM_BITS-1:0]   allele;
		logic [COUNT_BITS-1:0] hom_zero;
		logic [COUNT_BITS-1:0] het;
		logic [COUNT_BITS-1:0] hom_two;
		logic [COUNT_BITS-1:0] missing;
	} tally_t;

	typedef struct packed {
		logic              start;
		logic [SUM_BITS-1:0] num;
		logic [SUM_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [Q_BITS-1:0] quot;
	} div_rsp_t;

endpackage : gms_pkg
`default_nettype wire

// ===== sv/gms_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving floor(num * 2^16 / den) for num <= den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module gms_div import gms_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [REM_BITS-1:0]          rem_q;
	logic [SUM_BITS-1:0]          den_q;
	logic [Q_BITS-1:0]            quot_q;
	logic [$clog2(Q_BITS+1)-1:0]  cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [REM_BITS-1:0]          trial;
	logic                         fits;

	always_comb begin
		trial = (cnt_q == '0) ? rem_q : {rem_q[REM_BITS-2:0], 1'b0};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == Q_BITS - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, req.num};
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[Q_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule : gms_div
`default_nettype wire

// ===== sv/genotype_marker_stats_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Genotype marker statistics
// Per-marker genotype tallies in one memory with a fixed-point report.
// ----------------------------------------------------------------------------
// After reset the block zeroes the tally memory and takes no item until that
// is done. An add or clear item has a synchronous memory read, then a write
// back. A report item on a marker with called samples makes four passes
// through the shared bit-serial divider, each with a start state, the
// seventeen quotient bits and a step to take the quotient, then a multiply
// state. A report on a marker with no called samples goes straight to the
// output state, which waits for room in the output register. A finished
// report waits in the output register while the next item is taken.
module genotype_marker_stats_top import gms_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             command,
	input  wire logic [IDX_BITS-1:0]    marker_index,
	input  wire logic [7:0]             genotype,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        no_called,
	output logic [Q_BITS-1:0]           allele_freq,
	output logic signed [CODE_BITS-1:0] add_code_zero,
	output logic signed [CODE_BITS-1:0] add_code_one,
	output logic signed [CODE_BITS-1:0] add_code_two,
	output logic signed [CODE_BITS-1:0] dom_code_zero,
	output logic signed [CODE_BITS-1:0] dom_code_one,
	output logic signed [CODE_BITS-1:0] dom_code_two,
	output logic [Q_BITS-1:0]           share_hom_zero,
	output logic [Q_BITS-1:0]           share_het,
	output logic [Q_BITS-1:0]           share_hom_two,
	output logic [COUNT_BITS-1:0]       missing_count
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_FETCH  = 7'b0000100,
		S_DSTART = 7'b0001000,
		S_DWAIT  = 7'b0010000,
		S_MUL    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	localparam logic [Q_BITS-1:0]    ONE_Q    = Q_BITS'(1) << FRAC_BITS;
	localparam logic [CODE_BITS-1:0] ONE_CODE = CODE_BITS'(1) << FRAC_BITS;

	state_t                state_q;
	tally_t                mem [MARKERS];
	tally_t                rd_q;
	tally_t                wr_data;
	logic                  wr_en;
	logic [IDX_BITS-1:0]   wr_addr;
	logic [IDX_BITS-1:0]   clr_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [1:0]            cmd_q;
	logic [7:0]            geno_q;
	logic                  accept;
	logic                  nc_q;
	logic [1:0]            sel_q;
	logic [Q_BITS-1:0]     p_q;
	logic [Q_BITS-1:0]     s0_q;
	logic [Q_BITS-1:0]     s1_q;
	logic [Q_BITS-1:0]     s2_q;
	logic [PROD_BITS-1:0]  pp_q;
	logic [PROD_BITS-1:0]  pq_q;
	logic [PROD_BITS-1:0]  qq_q;
	logic [Q_BITS-1:0]     q_val;
	logic                  out_load;
	logic                  out_valid_q;
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	logic [CODE_BITS-1:0]  two_p;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[marker_index];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == S_FETCH) begin
			if (cmd_q == CMD_CLEAR) begin
				wr_en   = 1'b1;
				wr_data = '0;
			end else if (cmd_q == CMD_ADD) begin
				wr_en = 1'b1;
				if (geno_q > 8'd2) begin
					if (rd_q.missing != '1) begin
						wr_data.missing = rd_q.missing + 1'b1;
					end
				end else if (rd_q.called != '1) begin
					wr_data.called = rd_q.called + 1'b1;
					wr_data.allele = rd_q.allele + SUM_BITS'(geno_q[1:0]);
					case (geno_q[1:0])
						2'd0:    wr_data.hom_zero = rd_q.hom_zero + 1'b1;
						2'd1:    wr_data.het      = rd_q.het + 1'b1;
						default: wr_data.hom_two  = rd_q.hom_two + 1'b1;
					endcase
				end
			end
		end
	end

	always_comb begin
		div_req.start = (state_q == S_DSTART);
		div_req.den   = {1'b0, rd_q.called};
		case (sel_q)
			2'd0: begin
				div_req.num = rd_q.allele;
				div_req.den = {rd_q.called, 1'b0};
			end
			2'd1:    div_req.num = {1'b0, rd_q.hom_zero};
			2'd2:    div_req.num = {1'b0, rd_q.het};
			default: div_req.num = {1'b0, rd_q.hom_two};
		endcase
	end

	gms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_BITS'(MARKERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					sel_q <= '0;
					if (cmd_q != CMD_REPORT) begin
						state_q <= S_IDLE;
					end else if (rd_q.called == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DSTART;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_rsp.done) begin
						sel_q   <= sel_q + 1'b1;
						state_q <= (sel_q == 2'd3) ? S_MUL : S_DSTART;
					end
				end
				S_MUL: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign q_val = ONE_Q - p_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= marker_index;
			cmd_q  <= command;
			geno_q <= genotype;
		end
		if (state_q == S_FETCH) begin
			nc_q <= (rd_q.called == '0);
		end
		if (state_q == S_DWAIT && div_rsp.done) begin
			case (sel_q)
				2'd0:    p_q  <= div_rsp.quot;
				2'd1:    s0_q <= div_rsp.quot;
				2'd2:    s1_q <= div_rsp.quot;
				default: s2_q <= div_rsp.quot;
			endcase
		end
		if (state_q == S_MUL) begin
			pp_q <= p_q * p_q;
			pq_q <= p_q * q_val;
			qq_q <= q_val * q_val;
		end
	end

	assign two_p = {1'b0, p_q, 1'b0};

	always_ff @(posedge clk) begin
		if (out_load) begin
			missing_count <= rd_q.missing;
			no_called     <= nc_q;
			if (nc_q) begin
				allele_freq    <= '0;
				add_code_zero  <= '0;
				add_code_one   <= '0;
				add_code_two   <= '0;
				dom_code_zero  <= '0;
				dom_code_one   <= '0;
				dom_code_two   <= '0;
				share_hom_zero <= '0;
				share_het      <= '0;
				share_hom_two  <= '0;
			end else begin
				allele_freq    <= p_q;
				add_code_zero  <= two_p;
				add_code_one   <= two_p - ONE_CODE;
				add_code_two   <= two_p - {ONE_CODE[CODE_BITS-2:0], 1'b0};
				dom_code_zero  <= CODE_BITS'(0) - CODE_BITS'(pp_q >> (FRAC_BITS - 1));
				dom_code_one   <= CODE_BITS'(pq_q >> (FRAC_BITS - 1));
				dom_code_two   <= CODE_BITS'(0) - CODE_BITS'(qq_q >> (FRAC_BITS - 1));
				share_hom_zero <= s0_q;
				share_het      <= s1_q;
				share_hom_two  <= s2_q;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DWAIT)
		else $error("divider finished outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> p_q <= ONE_Q)
		else $error("allele frequency above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |->
			({2'b00, rd_q.hom_zero} + {2'b00, rd_q.het} + {2'b00, rd_q.hom_two})
			== {2'b00, rd_q.called})
		else $error("class counts disagree with called count");

endmodule : genotype_marker_stats_top
`default_nettype wire
